// ----- sv/cross_erode_dilate_stream_assert.svh -----
// assertion macros shared by the checker of cross_erode_dilate_stream
`ifndef CROSS_ERODE_DILATE_STREAM_ASSERT_SVH
`define CROSS_ERODE_DILATE_STREAM_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CED_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define CED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/ced_pkg.sv -----
// package with sizes, register codes, class codes and helpers of the cross filter
`timescale 1ns / 1ps
`default_nettype none

package ced_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DIM_W  = 11;
    localparam int PIX_W  = 8;
    localparam int IDX_W  = 2;

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;

    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;
    localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] REG_OPERATION    = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic OP_ERODE  = 1'b0;
    localparam logic OP_DILATE = 1'b1;

    // pixel class kept in the line store
    typedef logic [1:0] cls_t;
    localparam cls_t CLS_ZERO  = 2'd0;
    localparam cls_t CLS_FULL  = 2'd1;
    localparam cls_t CLS_OTHER = 2'd2;

    typedef struct packed {
        logic             last;
        logic [PIX_W-1:0] pixel;
    } result_t;

    function automatic cls_t classify(input logic [PIX_W-1:0] px);
        cls_t c;
        if (px == PIX_ZERO)
            c = CLS_ZERO;
        else if (px == PIX_FULL)
            c = CLS_FULL;
        else
            c = CLS_OTHER;
        return c;
    endfunction

    // zero counts as one, anything above the maximum is clamped
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    // a present neighbour that forces the result away from the default
    function automatic logic triggers(input logic present, input logic op, input cls_t c);
        logic t;
        if (!present)
            t = 1'b0;
        else if (op == OP_ERODE)
            t = (c == CLS_FULL);
        else
            t = (c == CLS_ZERO);
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- sv/ced_ram.sv -----
// generic simple dual-port ram, registered write-first read
`timescale 1ns / 1ps
`default_nettype none

module ced_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- sv/ced_out_buf.sv -----
// two-entry result buffer: output register plus skid stage
`timescale 1ns / 1ps
`default_nettype none

module ced_out_buf
    import ced_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire result_t in_data,
    output logic         in_ready,
    output logic         out_valid,
    output result_t      out_data,
    input  wire logic    out_ready
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end
        else if (in_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- sv/cross_erode_dilate_stream.sv -----
// top level of the streaming cross-shaped erosion / dilation filter
//
// channel   direction  signals                        contents
// s_axis    in         s_tvalid s_tready s_tdata      pixel_in [7:0]
//                      s_tuser                        flush
// m_axis    out        m_tvalid m_tready m_tdata      pixel_out [7:0]
//                      m_tlast                        frame_end
// cfg       in         cfg_wr_en cfg_index cfg_wdata  0 operation, 1 width, 2 height
//
// one transaction per clock while s_tready is high; the result of an item is
// registered into the output register, or into the skid stage when
// the output register is stalled
// the line store is two banks of MAX_WIDTH classes, one read port each, read
// one position ahead so data is ready when the next transaction arrives
// s_tready drops only when both output register and skid stage hold results
// reset clears position counters and loads configuration defaults; no clearing pass, the
// store is only read where the current frame has already written it
`timescale 1ns / 1ps
`default_nettype none

module cross_erode_dilate_stream
    import ced_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [PIX_W-1:0]     s_tdata,   // [7:0] pixel_in
    input  wire logic                 s_tuser,   // [0] flush
    // output stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [PIX_W-1:0]     m_tdata,   // [7:0] pixel_out
    output logic                      m_tlast,
    // configuration writes
    input  wire logic                 cfg_wr_en,
    input  wire logic [IDX_W-1:0]     cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_wdata
);

    // configuration registers
    logic             op_reg, op_next;
    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;

    // position of the next result and first-row intake count
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] seen_reg, seen_next;

    // sliding window on the current row: column c-1, column c,
    // and column 0 of the row being collected
    cls_t left_reg, left_next;
    cls_t mid_reg, mid_next;
    cls_t first_reg, first_next;

    logic             accept;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;
    logic             intake;
    logic             in_valid;
    logic             up_p, left_p, right_p;
    logic             hit;
    logic             last;
    cls_t             down_cls;
    cls_t             up_cls;
    cls_t             right_cls;

    // line store banks, bank index is the row parity
    logic             wr_en0, wr_en1;
    logic [COL_W-1:0] wr_addr;
    cls_t             wr_data;
    logic [COL_W-1:0] rd_addr0, rd_addr1;
    logic [COL_W-1:0] col_ahead;
    cls_t             rd_data0, rd_data1;

    logic             produce;
    result_t          res;
    result_t          out_res;

    assign accept   = s_tvalid && s_tready;
    assign w_eff    = eff_dim(width_reg, MAX_W_DIM);
    assign h_eff    = eff_dim(height_reg, MAX_H_DIM);
    assign col_inc  = DIM_W'(col_reg) + DIM_W'(1);
    assign row_inc  = DIM_W'(row_reg) + DIM_W'(1);
    assign intake   = seen_reg < w_eff;
    assign in_valid = row_inc < h_eff;
    assign down_cls = classify(s_tdata);

    // parity of the current row picks which bank feeds right and which feeds up
    assign right_cls = row_reg[0] ? rd_data1 : rd_data0;
    assign up_cls    = row_reg[0] ? rd_data0 : rd_data1;

    assign up_p    = (row_reg != '0);
    assign left_p  = (col_reg != '0);
    assign right_p = (col_inc < w_eff);

    assign hit = triggers(up_p, op_reg, up_cls) || triggers(in_valid, op_reg, down_cls) ||
                 triggers(left_p, op_reg, left_reg) || triggers(right_p, op_reg, right_cls);

    assign last = (row_inc == h_eff) && (col_inc == w_eff);

    always_comb
    begin
        op_next     = op_reg;
        width_next  = width_reg;
        height_next = height_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        seen_next   = seen_reg;
        left_next   = left_reg;
        mid_next    = mid_reg;
        first_next  = first_reg;
        wr_en0      = 1'b0;
        wr_en1      = 1'b0;
        wr_addr     = col_reg;
        wr_data     = down_cls;
        produce     = 1'b0;
        res.last    = last;
        res.pixel   = (op_reg == OP_ERODE) ? (hit ? PIX_FULL : PIX_ZERO)
                                           : (hit ? PIX_ZERO : PIX_FULL);

        if (accept)
        begin
            if (intake)
            begin
                // first row goes straight into bank 0, flush items are dropped
                if (!s_tuser)
                begin
                    wr_en0    = 1'b1;
                    wr_addr   = seen_reg[COL_W-1:0];
                    seen_next = seen_reg + DIM_W'(1);
                    if (seen_reg == '0)
                    begin
                        mid_next = down_cls;
                    end
                end
            end
            else if (!(in_valid && s_tuser))
            begin
                produce = 1'b1;
                if (in_valid)
                begin
                    // row below lands in the bank of the row above, same column
                    wr_en0 = row_reg[0];
                    wr_en1 = !row_reg[0];
                    if (col_reg == '0)
                    begin
                        first_next = down_cls;
                    end
                end
                left_next = mid_reg;
                if (last)
                begin
                    row_next  = '0;
                    col_next  = '0;
                    seen_next = '0;
                end
                else if (col_inc == w_eff)
                begin
                    col_next = '0;
                    row_next = row_reg + ROW_W'(1);
                    mid_next = (col_reg == '0) ? down_cls : first_reg;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                    mid_next = right_cls;
                end
            end
        end

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_OPERATION:
                begin
                    op_next = cfg_wdata[0];
                end
                REG_FRAME_WIDTH:
                begin
                    width_next = cfg_wdata;
                    row_next   = '0;
                    col_next   = '0;
                    seen_next  = '0;
                end
                REG_FRAME_HEIGHT:
                begin
                    height_next = cfg_wdata;
                    row_next    = '0;
                    col_next    = '0;
                    seen_next   = '0;
                end
                default:
                begin
                    op_next = op_reg;
                end
            endcase
        end
    end

    // read addresses follow the next position: right neighbour from the
    // current row's bank, up neighbour from the other bank
    assign col_ahead = col_next + COL_W'(1);
    assign rd_addr0  = row_next[0] ? col_next : col_ahead;
    assign rd_addr1  = row_next[0] ? col_ahead : col_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg     <= OP_ERODE;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            row_reg    <= '0;
            col_reg    <= '0;
            seen_reg   <= '0;
        end
        else
        begin
            op_reg     <= op_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            seen_reg   <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        mid_reg   <= mid_next;
        first_reg <= first_next;
    end

    ced_ram #(
        .WIDTH ($bits(cls_t)),
        .DEPTH (MAX_WIDTH)
    ) u_bank0 (
        .clk     (clk),
        .wr_en   (wr_en0),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr0),
        .rd_data (rd_data0)
    );

    ced_ram #(
        .WIDTH ($bits(cls_t)),
        .DEPTH (MAX_WIDTH)
    ) u_bank1 (
        .clk     (clk),
        .wr_en   (wr_en1),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr1),
        .rd_data (rd_data1)
    );

    ced_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (produce),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = out_res.pixel;
    assign m_tlast = out_res.last;

endmodule

`default_nettype wire

// ----- sv/ced_checker.sv -----
// port-level checker for cross_erode_dilate_stream and its bind
`timescale 1ns / 1ps
`default_nettype none

`include "cross_erode_dilate_stream_assert.svh"

module ced_checker
    import ced_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_tready,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [PIX_W-1:0] m_tdata,
    input wire logic             m_tlast
);

    logic pix_ok;
    logic out_stall;

    assign pix_ok    = (m_tdata == PIX_ZERO) || (m_tdata == PIX_FULL);
    assign out_stall = m_tvalid && !m_tready;

    // results are always pure black or white
    `CED_ASSERT_IMPL(a_pix_binary, clk, rst_n, m_tvalid, pix_ok)

    // input side only backs up while a result is waiting
    `CED_ASSERT_IMPL(a_stall_needs_out, clk, rst_n, !s_tready, m_tvalid)

    // ready falls only after an output stall
    `CED_ASSERT_IMPL(a_ready_fall, clk, rst_n, $fell(s_tready), $past(out_stall))

    // a stalled result holds
    `CED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_tvalid && $stable({m_tdata, m_tlast}))

endmodule

bind cross_erode_dilate_stream ced_checker u_ced_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- dv/testbench.sv -----
// self-checking testbench for the streaming cross-shaped erosion / dilation filter
`timescale 1ns / 1ps

module testbench;
    import ced_pkg::*;

    // the block registers its answer to a transaction; a margin lets it settle
    // before a register write or the final verdict
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES   = 24;
    // cycles in a row with no transaction and no register write
    localparam int unsigned STALL_LIMIT   = 2000;
    // payload items of the random part; with the directed cases and the
    // one-column frame the run sends about 1650 items
    localparam int unsigned RANDOM_ITEMS  = 520;
    localparam int unsigned REPORT_CAP    = 200;
    // index with no register behind it, writes to it are dropped
    localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int unsigned DIM_TOP = (1 << DIM_W) - 1;

    // one input transaction: an image pixel or a pad item
    typedef struct packed {
        logic             pad;
        logic [PIX_W-1:0] pixel;
    } px_item_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [PIX_W-1:0] s_tdata   = '0;   // [7:0] pixel_in
    logic             s_tuser   = 1'b0; // [0] flush
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [PIX_W-1:0] m_tdata;          // [7:0] pixel_out
    logic             m_tlast;          // frame_end
    logic             cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0] cfg_wdata = '0;

    // items waiting for the driver, results waiting for the monitor
    px_item_t    in_pixel_q [$];
    result_t     out_pixel_q [$];

    // mirror of the filter: class line store, mode, sizes and scan position
    cls_t        line_cls [0:2*MAX_WIDTH-1];
    logic        mode_op;
    int unsigned span_w;
    int unsigned span_h;
    int unsigned res_row;
    int unsigned res_col;
    int unsigned row0_taken;

    // driver and monitor pacing
    int unsigned send_wait;
    bit          send_burst;
    int unsigned recv_wait;
    bit          recv_burst;
    px_item_t    next_item;
    result_t     want;

    int unsigned payload_items;
    int unsigned items_taken;
    int unsigned results_seen;
    int unsigned frames_done;
    int unsigned cfg_writes;
    int unsigned mismatches;
    int unsigned quiet_cycles;

    cross_erode_dilate_stream i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor helpers
    // ------------------------------------------------------------------

    // a size of zero means one, anything past the store is clipped to it
    function automatic int unsigned usable_dim(input logic [DIM_W-1:0] v,
                                               input int unsigned top);
        int unsigned d;
        d = 32'(v);
        if (d == 0)
            d = 1;
        else if (d > top)
            d = top;
        return d;
    endfunction

    function automatic cls_t pixel_class(input logic [PIX_W-1:0] px);
        cls_t c;
        case (px)
            PIX_ZERO: c = CLS_ZERO;
            PIX_FULL: c = CLS_FULL;
            default:  c = CLS_OTHER;
        endcase
        return c;
    endfunction

    // rows alternate between the two halves of the store
    function automatic int unsigned bank_base(input int unsigned row);
        return (row & 1) * MAX_WIDTH;
    endfunction

    // erosion is pulled up by a full neighbour, dilation pulled down by an empty one
    function automatic logic flips(input logic present, input cls_t c);
        logic f;
        f = 1'b0;
        if (present)
            f = (mode_op == OP_ERODE) ? (c == CLS_FULL) : (c == CLS_ZERO);
        return f;
    endfunction

    // advance the mirror by one accepted item, queue the pixel it yields
    task automatic apply_cross_filter(input px_item_t it);
        int unsigned below;
        logic        below_ok;
        logic        hit;
        logic        at_end;
        cls_t        c_up;
        cls_t        c_dn;
        cls_t        c_lf;
        cls_t        c_rt;
        result_t     r;
        if (row0_taken < span_w)
        begin
            // first row only fills the store, pads are dropped
            if (!it.pad)
            begin
                line_cls[row0_taken] = pixel_class(it.pixel);
                row0_taken++;
            end
            return;
        end
        below    = res_row + 1;
        below_ok = below < span_h;
        // a pad where an image pixel is due is dropped
        if (below_ok && it.pad)
            return;
        c_up = CLS_OTHER;
        c_dn = CLS_OTHER;
        c_lf = CLS_OTHER;
        c_rt = CLS_OTHER;
        // past the last image row any item is a pad, its pixel unused
        if (below_ok)
            c_dn = pixel_class(it.pixel);
        if (res_row > 0)
            c_up = line_cls[bank_base(res_row - 1) + res_col];
        if (res_col > 0)
            c_lf = line_cls[bank_base(res_row) + res_col - 1];
        if (res_col + 1 < span_w)
            c_rt = line_cls[bank_base(res_row) + res_col + 1];
        hit = flips(res_row > 0, c_up) || flips(below_ok, c_dn) ||
              flips(res_col > 0, c_lf) || flips(res_col + 1 < span_w, c_rt);
        // up neighbour is read before the incoming row takes its slot
        if (below_ok)
            line_cls[bank_base(below) + res_col] = c_dn;
        if (mode_op == OP_ERODE)
            r.pixel = hit ? PIX_FULL : PIX_ZERO;
        else
            r.pixel = hit ? PIX_ZERO : PIX_FULL;
        at_end = (res_row + 1 == span_h) && (res_col + 1 == span_w);
        r.last = at_end;
        out_pixel_q.push_back(r);
        if (at_end)
        begin
            res_row    = 0;
            res_col    = 0;
            row0_taken = 0;
        end
        else
        begin
            res_col++;
            if (res_col >= span_w)
            begin
                res_col = 0;
                res_row++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        mismatches++;
        // keep the log short on a badly broken block
        if (mismatches <= REPORT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // register write while the filter is idle, mirrored once the block took it
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_OPERATION:
                mode_op = val[0];
            REG_FRAME_WIDTH, REG_FRAME_HEIGHT:
            begin
                if (idx == REG_FRAME_WIDTH)
                    span_w = usable_dim(val, MAX_WIDTH);
                else
                    span_h = usable_dim(val, MAX_HEIGHT);
                // any size write starts a new frame
                res_row    = 0;
                res_col    = 0;
                row0_taken = 0;
            end
            default:
                ;
        endcase
        cfg_writes++;
        @(negedge clk);
    endtask

    // upper bits of the operation word carry noise, only bit 0 counts
    task automatic set_operation(input logic op);
        logic [DIM_W-1:0] val;
        val    = DIM_W'($urandom);
        val[0] = op;
        write_reg(REG_OPERATION, val);
    endtask

    task automatic push_item(input logic pad, input logic [PIX_W-1:0] px);
        px_item_t it;
        it.pad   = pad;
        it.pixel = px;
        in_pixel_q.push_back(it);
    endtask

    // mostly binary images, with some grey values that neither mode reacts to
    function automatic logic [PIX_W-1:0] draw_pixel();
        logic [PIX_W-1:0] px;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: px = PIX_ZERO;
            4, 5, 6, 7: px = PIX_FULL;
            default:    px = PIX_W'($urandom);
        endcase
        return px;
    endfunction

    // zero and one now and then, otherwise a small size
    function automatic logic [DIM_W-1:0] pick_dim(input int unsigned most);
        logic [DIM_W-1:0] d;
        case ($urandom_range(0, 19))
            0:       d = '0;
            1:       d = DIM_W'(1);
            default: d = DIM_W'($urandom_range(2, most));
        endcase
        return d;
    endfunction

    function automatic int unsigned draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 3);
    endfunction

    // one frame at the current size: image pixels with stray pads, then a
    // row of pads, some of them pixels that the block treats as pads;
    // a cut frame stops at a random point and is left unfinished
    task automatic load_frame(input bit cut);
        int unsigned n_pix;
        int unsigned n_all;
        int unsigned stop_at;
        n_pix   = span_w * span_h;
        n_all   = n_pix + span_w;
        stop_at = cut ? $urandom_range(1, n_all - 1) : n_all;
        for (int unsigned k = 0; k < stop_at; k++)
        begin
            if (k < n_pix)
            begin
                if ($urandom_range(0, 19) == 0)
                    push_item(1'b1, PIX_W'($urandom));
                push_item(1'b0, draw_pixel());
            end
            else
                push_item($urandom_range(0, 6) != 0, draw_pixel());
        end
        payload_items += stop_at;
    endtask

    // nothing queued, nothing in flight, nothing expected, then a pause
    task automatic wait_drained(input int unsigned extra);
        while (in_pixel_q.size() != 0 || s_tvalid || out_pixel_q.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // driver: one transaction per item, random gap after each
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= 1'b0;
            send_wait  = 0;
            send_burst = 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_cross_filter('{pad: s_tuser, pixel: s_tdata});
                items_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_wait != 0)
                begin
                    s_tvalid <= 1'b0;
                    send_wait--;
                end
                else if (in_pixel_q.size() != 0)
                begin
                    next_item = in_pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.pixel;
                    s_tuser  <= next_item.pad;
                    // switch now and then between gappy and back-to-back
                    if ($urandom_range(0, 63) == 0)
                        send_burst = !send_burst;
                    send_wait = draw_wait(send_burst);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: compares every output transaction with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_wait  = 0;
            recv_burst = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (out_pixel_q.size() == 0)
                    report_mismatch($sformatf("pixel %0d last %0b with nothing pending",
                                              m_tdata, m_tlast));
                else
                begin
                    want = out_pixel_q.pop_front();
                    if (m_tdata !== want.pixel)
                        report_mismatch($sformatf("result %0d: pixel %0d, want %0d",
                                                  results_seen, m_tdata, want.pixel));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("result %0d: frame end %0b, want %0b",
                                                  results_seen, m_tlast, want.last));
                end
                if (m_tlast === 1'b1)
                    frames_done++;
                results_seen++;
                if ($urandom_range(0, 63) == 0)
                    recv_burst = !recv_burst;
                recv_wait = draw_wait(recv_burst);
            end
            if (recv_wait != 0)
            begin
                m_tready <= 1'b0;
                recv_wait--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without any transaction or register write
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, out_pixel_q.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence: directed cases, a tall frame, then random frames
    // ------------------------------------------------------------------
    initial
    begin
        bit cut;
        mode_op    = OP_ERODE;
        span_w     = usable_dim(WIDTH_RST, MAX_WIDTH);
        span_h     = usable_dim(HEIGHT_RST, MAX_HEIGHT);
        res_row    = 0;
        res_col    = 0;
        row0_taken = 0;
        quiet_cycles  = 0;
        payload_items = 0;
        items_taken   = 0;
        results_seen  = 0;
        frames_done   = 0;
        cfg_writes    = 0;
        mismatches    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // write to an unused index, nothing may change
        write_reg(REG_SPARE, DIM_W'($urandom));

        // erosion on 3x2: zero, full and grey pixels, stray pads, pixels as pads
        set_operation(OP_ERODE);
        write_reg(REG_FRAME_WIDTH, DIM_W'(3));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(2));
        push_item(1'b1, 8'h5A);     // pad during the first row: dropped
        push_item(1'b0, PIX_ZERO);
        push_item(1'b0, PIX_FULL);
        push_item(1'b0, 8'h80);
        push_item(1'b0, PIX_FULL);
        push_item(1'b1, 8'hC3);     // pad while image rows remain: dropped
        push_item(1'b0, PIX_ZERO);
        push_item(1'b0, 8'h01);
        push_item(1'b1, PIX_ZERO);
        push_item(1'b0, 8'hFE);     // pixel after the last row acts as a pad
        push_item(1'b1, PIX_FULL);
        wait_drained(SETTLE_CYCLES);

        // dilation, zero sizes taken as one: two 1x1 frames back to back
        set_operation(OP_DILATE);
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, '0);
        push_item(1'b0, 8'h7F);
        push_item(1'b1, PIX_ZERO);
        push_item(1'b0, PIX_ZERO);
        push_item(1'b0, PIX_FULL);
        wait_drained(SETTLE_CYCLES);

        // part of a frame, then a size write restarts it
        set_operation(OP_ERODE);
        write_reg(REG_FRAME_WIDTH, DIM_W'(2));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(3));
        push_item(1'b0, PIX_FULL);
        push_item(1'b0, PIX_ZERO);
        push_item(1'b0, PIX_ZERO);
        wait_drained(SETTLE_CYCLES);
        write_reg(REG_FRAME_HEIGHT, DIM_W'(2));

        // tallest one-column frame, height written at or past the maximum
        set_operation(OP_ERODE);
        write_reg(REG_FRAME_WIDTH, DIM_W'(1));
        write_reg(REG_FRAME_HEIGHT, DIM_W'($urandom_range(MAX_HEIGHT, DIM_TOP)));
        load_frame(1'b0);
        wait_drained(SETTLE_CYCLES);

        // random frames; a cut frame must be followed by a restart
        set_operation(1'($urandom_range(0, 1)));
        write_reg(REG_FRAME_WIDTH, pick_dim(16));
        write_reg(REG_FRAME_HEIGHT, pick_dim(6));
        payload_items = 0;
        while (payload_items < RANDOM_ITEMS)
        begin
            cut = ($urandom_range(0, 7) == 0);
            load_frame(cut);
            if (cut || $urandom_range(0, 2) == 0)
            begin
                wait_drained(SETTLE_CYCLES);
                set_operation(1'($urandom_range(0, 1)));
                if (cut || $urandom_range(0, 1) == 0)
                    write_reg(REG_FRAME_WIDTH, pick_dim(16));
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_FRAME_HEIGHT, pick_dim(6));
            end
        end

        wait_drained(TAIL_CYCLES);
        $display("summary: %0d input and %0d output transactions, %0d frames, %0d register writes",
                 items_taken, results_seen, frames_done, cfg_writes);
        $display("summary: both modes, sizes 1x1 to 16x6, a %0d-row column, stray pads, cuts",
                 MAX_HEIGHT);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- cross_erode_dilate_stream.f -----
+incdir+sv
sv/ced_pkg.sv
sv/ced_ram.sv
sv/ced_out_buf.sv
sv/cross_erode_dilate_stream.sv
sv/ced_checker.sv
dv/testbench.sv
